/* rtl/mrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants of the multi-reader ring block
// Access codes, the queued command record and depth helpers.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int NUM_RINGS_DEF   = 4;
  localparam int NUM_CLIENTS_DEF = 8;
  localparam int MAX_DEPTH_DEF   = 256;
  localparam int ENTRY_BITS_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int DEPTH_REG_BITS  = 9;
  localparam int DEPTH_RESET     = 256;
  localparam int DEPTH_MIN       = 3;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_READ_OLD = 2'd1,
    FUNC_READ_NEW = 2'd2,
    FUNC_CHECK    = 2'd3
  } func_t;

  // one classified command on its way from front to back
  typedef struct packed {
    func_t       op;
    logic        ring_ok;
    logic        client_ok;
    logic [1:0]  ring;
    logic [2:0]  client;
    logic [63:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // last usable slot index for a depth register value, clamped to the legal range
  function automatic int depth_last(input logic [DEPTH_REG_BITS-1:0] v, input int max_depth);
    int d;
    d = int'(v);
    if (d < DEPTH_MIN) d = DEPTH_MIN;
    if (d > max_depth) d = max_depth;
    return d - 1;
  endfunction

endpackage

/* rtl/mrr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_front: command intake
// Takes a command when the queue has room and tags ring/client range checks.
// ----------------------------------------------------------------------------
module mrr_front #(
  parameter int NUM_RINGS   = mrr_pkg::NUM_RINGS_DEF,
  parameter int NUM_CLIENTS = mrr_pkg::NUM_CLIENTS_DEF
) (
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [1:0]          ring_select,
  input  logic [2:0]          client_id,
  input  logic [63:0]         entry_in,
  input  mrr_pkg::q_status_t  q_status,
  output logic                push,
  output mrr_pkg::item_t      push_item
);

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    push_item.op        = mrr_pkg::func_t'(func);
    push_item.ring_ok   = int'(ring_select) < NUM_RINGS;
    push_item.client_ok = int'(client_id) < NUM_CLIENTS;
    push_item.ring      = ring_select;
    push_item.client    = client_id;
    push_item.data      = entry_in;
  end

endmodule

/* rtl/mrr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_queue: short command queue
// Small FIFO of classified commands between intake and execution.
// ----------------------------------------------------------------------------
module mrr_queue #(
  parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mrr_pkg::item_t     push_item,
  input  logic               pop,
  output mrr_pkg::item_t     head,
  output mrr_pkg::q_status_t status
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mrr_pkg::item_t slots [QUEUE_DEPTH];
  logic [IW-1:0]  wr_ptr;
  logic [IW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/mrr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_back: ring execution
// Holds ring pointers and entry memory, runs one command per cycle.
// ----------------------------------------------------------------------------
module mrr_back #(
  parameter int NUM_RINGS   = mrr_pkg::NUM_RINGS_DEF,
  parameter int NUM_CLIENTS = mrr_pkg::NUM_CLIENTS_DEF,
  parameter int MAX_DEPTH   = mrr_pkg::MAX_DEPTH_DEF,
  parameter int ENTRY_BITS  = mrr_pkg::ENTRY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mrr_pkg::DEPTH_REG_BITS-1:0] cfg_data,
  input  logic                               exec,
  input  mrr_pkg::item_t                     item,
  output logic                               done,
  output logic                               got_entry,
  output logic                               pending,
  output logic [63:0]                        entry_out
);

  localparam int PW  = $clog2(MAX_DEPTH);
  localparam int RW  = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int KW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int AW  = $clog2(NUM_RINGS * MAX_DEPTH);
  localparam int MEM_WORDS = NUM_RINGS * MAX_DEPTH;

  logic [PW-1:0] d_last;
  logic [PW-1:0] wptr [NUM_RINGS];
  logic [PW-1:0] rptr [NUM_RINGS][NUM_CLIENTS];

  logic [ENTRY_BITS-1:0] mem [MEM_WORDS];
  logic [ENTRY_BITS-1:0] rd_data;

  logic [RW-1:0] ri;
  logic [KW-1:0] ci;
  logic [PW-1:0] wp, rp, ahead, ahead_next, last;
  logic          pend, rd_hit, act;
  logic [PW-1:0] slot;
  logic [AW-1:0] addr;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p, input logic [PW-1:0] lim);
    return (p == lim) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    ri         = RW'(item.ring);
    ci         = KW'(item.client);
    act        = exec && item.ring_ok;
    wp         = wptr[ri];
    rp         = rptr[ri][ci];
    pend       = item.ring_ok && item.client_ok && (rp != wp);
    ahead      = nxt(wp, d_last);
    ahead_next = nxt(ahead, d_last);
    last       = (wp == '0) ? d_last : wp - PW'(1);
    rd_hit     = pend && ((item.op == mrr_pkg::FUNC_READ_OLD) ||
                          (item.op == mrr_pkg::FUNC_READ_NEW));
    case (item.op)
      mrr_pkg::FUNC_WRITE:    slot = wp;
      mrr_pkg::FUNC_READ_OLD: slot = rp;
      mrr_pkg::FUNC_READ_NEW: slot = last;
      default:                slot = wp;
    endcase
    addr = AW'(ri) * AW'(MAX_DEPTH) + AW'(slot);
  end

  // entry memory, single port
  always_ff @(posedge clk) begin
    if (act && (item.op == mrr_pkg::FUNC_WRITE)) begin
      mem[addr] <= item.data[ENTRY_BITS-1:0];
    end
    if (exec && rd_hit) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_last <= PW'(mrr_pkg::depth_last(
                  mrr_pkg::DEPTH_REG_BITS'(mrr_pkg::DEPTH_RESET), MAX_DEPTH));
      for (int r = 0; r < NUM_RINGS; r++) begin
        wptr[r] <= '0;
        for (int c = 0; c < NUM_CLIENTS; c++) begin
          rptr[r][c] <= '0;
        end
      end
    end else if (cfg_we) begin
      d_last <= PW'(mrr_pkg::depth_last(cfg_data, MAX_DEPTH));
      for (int r = 0; r < NUM_RINGS; r++) begin
        wptr[r] <= '0;
        for (int c = 0; c < NUM_CLIENTS; c++) begin
          rptr[r][c] <= '0;
        end
      end
    end else if (act) begin
      case (item.op)
        mrr_pkg::FUNC_WRITE: begin
          // readers sitting on the slot about to be overrun lose their oldest entry
          for (int c = 0; c < NUM_CLIENTS; c++) begin
            if (rptr[ri][c] == ahead) begin
              rptr[ri][c] <= ahead_next;
            end
          end
          wptr[ri] <= ahead;
        end
        mrr_pkg::FUNC_READ_OLD: begin
          if (pend) rptr[ri][ci] <= nxt(rp, d_last);
        end
        mrr_pkg::FUNC_READ_NEW: begin
          if (pend) rptr[ri][ci] <= wp;
        end
        default: begin
        end
      endcase
    end
  end

  logic res_got;

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      res_got <= 1'b0;
      pending <= 1'b0;
    end else begin
      done    <= exec;
      res_got <= exec && rd_hit;
      pending <= exec && pend;
    end
  end

  assign got_entry = res_got;
  assign entry_out = res_got ? 64'(rd_data) : 64'd0;

endmodule

/* rtl/multi_reader_overwrite_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_overwrite_ring: multi-reader ring buffers, overwrite oldest
// Top level: intake, command queue and execution with per-client pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func/ring_select/client_id/entry_in with start;
//   the transfer happens on a clock edge with start high and busy low.
//   func: write, read oldest, read newest, check for pending data.
//   Result channel: one result per command, shown for exactly one cycle
//   with done high (got_entry, pending, entry_out). The receiver cannot
//   stall; results come out in command order.
//   Timing: the command executes from the queue head in the cycle after
//   its transfer; done is high in the cycle after that.
//   Throughput: one command per cycle, set by the single entry-memory
//   port touched once per command; busy only rises if the queue fills.
//   Config channel: cfg_valid/cfg_ready transfer of the ring depth on cfg_data, taken when
//   the queue is empty. A depth write empties every ring (all pointers 0).
//   Reset: pointers go to 0 and the depth to its full value; entry memory
//   keeps whatever it held and needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_reader_overwrite_ring #(
  parameter int NUM_RINGS   = mrr_pkg::NUM_RINGS_DEF,
  parameter int NUM_CLIENTS = mrr_pkg::NUM_CLIENTS_DEF,
  parameter int MAX_DEPTH   = mrr_pkg::MAX_DEPTH_DEF,
  parameter int ENTRY_BITS  = mrr_pkg::ENTRY_BITS_DEF,
  parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic [1:0]                         ring_select,
  input  logic [2:0]                         client_id,
  input  logic [63:0]                        entry_in,
  // result channel
  output logic                               done,
  output logic                               got_entry,
  output logic                               pending,
  output logic [63:0]                        entry_out,
  // depth register write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrr_pkg::DEPTH_REG_BITS-1:0] cfg_data
);

  mrr_pkg::item_t     push_item;
  mrr_pkg::item_t     head;
  mrr_pkg::q_status_t q_status;
  logic               push;
  logic               exec;

  // back end drains one queued command per cycle
  assign exec      = !q_status.empty;
  // depth changes only with nothing queued
  assign cfg_ready = q_status.empty;

  mrr_front #(
    .NUM_RINGS   (NUM_RINGS),
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .func        (func),
    .ring_select (ring_select),
    .client_id   (client_id),
    .entry_in    (entry_in),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  mrr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (exec),
    .head      (head),
    .status    (q_status)
  );

  mrr_back #(
    .NUM_RINGS   (NUM_RINGS),
    .NUM_CLIENTS (NUM_CLIENTS),
    .MAX_DEPTH   (MAX_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .exec      (exec),
    .item      (head),
    .done      (done),
    .got_entry (got_entry),
    .pending   (pending),
    .entry_out (entry_out)
  );

endmodule
